### rtl/rtoa_pkg.sv
package rtoa_pkg;

    // Radix register
    localparam int RADIX_W     = 6;
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 36;
    localparam int RADIX_RESET = 10;

    // Output character width
    localparam int CHAR_W = 7;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_STORE = 4'b0100,
        ST_EMIT  = 4'b1000
    } back_state_t;

    // Map a digit value to '0'-'9' then 'A'-'Z'
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {1'b0, d};
        if (d < RADIX_W'(10))
            return CHAR_W'(48) + dw;
        else
            return CHAR_W'(55) + dw;
    endfunction

    // Clamp a written radix into the supported range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_W'(RADIX_MIN))
            return RADIX_W'(RADIX_MIN);
        else if (r > RADIX_W'(RADIX_MAX))
            return RADIX_W'(RADIX_MAX);
        else
            return r;
    endfunction

endpackage

### rtl/rtoa_front.sv
module rtoa_front
    import rtoa_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  logic                  start,
    input  logic [63:0]           value,
    input  logic                  queue_full,
    output logic                  busy,
    output logic                  push,
    output logic [VALUE_BITS:0]   push_data
);

    logic [VALUE_BITS-1:0] value_masked;
    logic                  is_zero;

    // Drop the bits above the value width and flag zero
    assign value_masked = value[VALUE_BITS-1:0];
    assign is_zero      = (value_masked == '0);

    // Accept a word whenever the queue has room
    assign busy      = queue_full;
    assign push      = start && !queue_full;
    assign push_data = {is_zero, value_masked};

endmodule

### rtl/rtoa_queue.sv
module rtoa_queue
    import rtoa_pkg::*;
#(
    parameter int WIDTH = 65
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/rtoa_back.sv
module rtoa_back
    import rtoa_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [RADIX_W-1:0]   radix,
    input  logic                 queue_empty,
    input  logic [VALUE_BITS:0]  queue_data,
    output logic                 pop,
    output logic                 digit_valid,
    output logic [CHAR_W-1:0]    digit_char,
    output logic                 last
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);

    back_state_t             state_reg, state_next;
    logic [VALUE_BITS-1:0]   dividend_reg, dividend_next;
    logic [RADIX_W-1:0]      rem_reg, rem_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_last_reg, out_last_next;
    logic [RADIX_W-1:0]      rd_data_reg;

    logic [RADIX_W-1:0]      digit_store [MAX_DIGITS];
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [RADIX_W-1:0]      mem_wdata;

    logic [RADIX_W:0]        rem_shift;
    logic [RADIX_W:0]        rem_sub;
    logic                    rem_ge;
    logic [RADIX_W-1:0]      rem_step;
    logic [CNT_W-1:0]        count_inc;
    logic                    item_zero;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dividend_reg[VALUE_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, radix});
    assign rem_sub   = rem_shift - {1'b0, radix};
    assign rem_step  = rem_ge ? rem_sub[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];

    // Saturate the digit count at the store depth
    assign count_inc = (count_reg < CNT_W'(MAX_DIGITS)) ? count_reg + CNT_W'(1) : count_reg;
    assign item_zero = queue_data[VALUE_BITS];

    assign pop = (state_reg == ST_IDLE) && !queue_empty;

    // Sequencer: take an item, divide digit by digit, then play out in reverse
    always_comb
    begin
        state_next     = state_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    if (item_zero)
                    begin
                        // Zero gives the single digit zero
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = '0;
                        count_next = CNT_W'(1);
                        ptr_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        dividend_next = queue_data[VALUE_BITS-1:0];
                        rem_next      = '0;
                        bit_next      = '0;
                        count_next    = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                dividend_next = {dividend_reg[VALUE_BITS-2:0], rem_ge};
                rem_next      = rem_step;
                bit_next      = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(VALUE_BITS - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                // Keep the remainder unless the store is already full
                mem_we     = (count_reg < CNT_W'(MAX_DIGITS));
                count_next = count_inc;
                rem_next   = '0;
                bit_next   = '0;
                if (dividend_reg == '0)
                begin
                    ptr_next   = IDX_W'(count_inc - CNT_W'(1));
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_last_next  = (ptr_reg == '0);
                if (ptr_reg == '0)
                    state_next = ST_IDLE;
                else
                    ptr_next = ptr_reg - IDX_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dividend_reg  <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dividend_reg  <= dividend_next;
            rem_reg       <= rem_next;
            bit_reg       <= bit_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Digit store: one write port, registered read at the play-out pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_store[mem_waddr] <= mem_wdata;
        rd_data_reg <= digit_store[ptr_reg];
    end

    assign digit_valid = out_valid_reg;
    assign digit_char  = digit_to_char(rd_data_reg);
    assign last        = out_last_reg;

endmodule

### rtl/radix_integer_to_ascii.sv
// Integer to ASCII conversion in a programmable radix.
//
// Input: pulse start with value while busy is low; the word is taken at that
// edge. Only the low VALUE_BITS bits of value are used. A two-entry queue sits
// between the accepting front and the converting back, so busy rises only when
// two words are waiting behind the one in conversion.
// Config: write radix_data with radix_valid; radix_ready is always high. Values
// below 2 store 2, above 36 store 36. Write only while no conversion is open.
// Output: one character per cycle on digit_char with digit_valid, most
// significant digit first, '0'-'9' then 'A'-'Z'; last marks the final digit.
// The receiver cannot stall; each character is shown for exactly one cycle.
// Sequence: each digit takes one pass of the bit-serial restoring divider over
// all VALUE_BITS dividend bits and a store step; the digits then stream out
// through a registered read of the digit store. A zero value skips the
// divider and stores the single digit zero directly.
// At most MAX_DIGITS low-order digits are kept and emitted.
// Reset: radix returns to 10, queue and sequencer go empty and idle.
module radix_integer_to_ascii
    import rtoa_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [63:0]         value,
    input  logic                radix_valid,
    output logic                radix_ready,
    input  logic [RADIX_W-1:0]  radix_data,
    output logic                digit_valid,
    output logic [CHAR_W-1:0]   digit_char,
    output logic                last
);

    logic [RADIX_W-1:0]  radix_reg;
    logic                queue_full;
    logic                queue_empty;
    logic                push;
    logic                pop;
    logic [VALUE_BITS:0] push_data;
    logic [VALUE_BITS:0] pop_data;

    // Radix register, clamped on write
    assign radix_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_W'(RADIX_RESET);
        else if (radix_valid && radix_ready)
            radix_reg <= clamp_radix(radix_data);
    end

    rtoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .start      (start),
        .value      (value),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    rtoa_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    rtoa_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix       (radix_reg),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last        (last)
    );

endmodule
